// ----- hdl/pgd_pkg.sv -----
// pgd_pkg: shared types and constants for the gyro-damped positional pid core
// register index codes, configuration struct, fixed widths and saturation limits
// no dependencies
package pgd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P        = 3'd0,
    REG_GAIN_I        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_RATE_OFFSET   = 3'd3,
    REG_RATE_DEADBAND = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic signed [16:0] rate_offset;
    logic        [15:0] rate_deadband;
  } cfg_t;

  localparam logic signed [16:0] RATE_OFFSET_RST   = 17'sd1639;
  localparam logic        [15:0] RATE_DEADBAND_RST = 16'd1280;

  localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

endpackage

// ----- hdl/pgd_cfg.sv -----
// pgd_cfg: configuration register file of the gyro-damped pid core
// decodes register index writes into a cfg_t struct; depends on pgd_pkg
module pgd_cfg import pgd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        REG_GAIN_P:        cfg_nxt.gain_p        = $signed(wr_data[15:0]);
        REG_GAIN_I:        cfg_nxt.gain_i        = $signed(wr_data[15:0]);
        REG_GAIN_D:        cfg_nxt.gain_d        = $signed(wr_data[15:0]);
        REG_RATE_OFFSET:   cfg_nxt.rate_offset   = $signed(wr_data);
        REG_RATE_DEADBAND: cfg_nxt.rate_deadband = wr_data[15:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p        <= '0;
      cfg_r.gain_i        <= '0;
      cfg_r.gain_d        <= '0;
      cfg_r.rate_offset   <= RATE_OFFSET_RST;
      cfg_r.rate_deadband <= RATE_DEADBAND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/pgd_intg.sv -----
// pgd_intg: saturating signed 32-bit error integral
// updated once per input transfer; depends on pgd_pkg
module pgd_intg import pgd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic signed [16:0] err,
  output logic signed [31:0] sum,
  output logic               sat
);

  logic signed [31:0] esum_r;
  logic signed [31:0] esum_nxt;
  logic signed [32:0] wide;

  always_comb begin
    wide = 33'(esum_r) + 33'(err);
    sat  = 1'b0;
    priority if (!wide[32] && wide[31]) begin
      esum_nxt = INT32_MAX;
      sat      = 1'b1;
    end else if (wide[32] && !wide[31]) begin
      esum_nxt = INT32_MIN;
      sat      = 1'b1;
    end else begin
      esum_nxt = wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esum_r <= '0;
    end else if (load) begin
      esum_r <= esum_nxt;
    end
  end

  assign sum = esum_nxt;

endmodule

// ----- hdl/positional_pid_gyro_damped_core.sv -----
// positional_pid_gyro_damped_core: top level of the gyro-damped positional pid
// four-register pipeline around pgd_cfg and pgd_intg; depends on pgd_pkg
//
// usage
//   input channel: in_valid/in_stall with setpoint, measured and yaw rate.
//   an item transfers on a rising edge with in_valid high and in_stall low.
//   result channel: out_valid/out_stall with drive and saturated flag.
//   config channel: cfg_valid/cfg_ready with register index and data;
//   cfg_ready is always high, unknown indexes are dropped. write only when
//   the block is idle.
//   order: the input transfer passes the input stage, multiplier stage,
//   reciprocal stage and output register before out_valid rises; the
//   integral is updated in the transfer cycle itself. throughput: one item
//   per cycle while out_stall is low, set by the four pipeline registers.
//   a stalled receiver holds the output; earlier stages keep filling and
//   in_stall rises only when all four stages hold items.
//   reset clears all stage valid bits, the integral and the registers to
//   their defaults.
module positional_pid_gyro_damped_core import pgd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [15:0]    in_setpoint,
  input  logic signed [15:0]    in_measured,
  input  logic signed [19:0]    in_yaw_rate,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_drive,
  output logic                  out_saturated,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [30:0] RECIP_100 = 31'd1374389535;
  localparam logic [29:0] DIV_BIAS  = 30'd419430400;
  localparam logic signed [24:0] QUOT_BIAS = 25'sd4194304;

  cfg_t cfg;

  logic accept;
  logic adv1, adv2, adv3, adv4;

  logic v1_r, v2_r, v3_r, out_valid_r;

  logic signed [16:0] err;
  logic signed [31:0] isum;
  logic               isat;
  logic signed [20:0] rate_raw;
  logic        [20:0] rate_mag;
  logic signed [20:0] rate_cor;

  logic signed [16:0] s1_err_r;
  logic signed [31:0] s1_sum_r;
  logic signed [20:0] s1_rate_r;
  logic               s1_sat_r;

  logic signed [32:0] prod_p;
  logic signed [47:0] prod_i;
  logic signed [36:0] prod_d;
  logic signed [48:0] s2_a_nxt;
  logic signed [48:0] s2_a_r;
  logic signed [28:0] s2_x_r;
  logic               s2_sat_r;

  logic [29:0]        div_in;
  logic [60:0]        div_prod;
  logic [23:0]        div_q;
  logic signed [23:0] s3_qd_nxt;
  logic signed [48:0] s3_a_r;
  logic signed [23:0] s3_qd_r;
  logic               s3_sat_r;

  logic signed [49:0] total;
  logic signed [49:0] floored;
  logic               ovf_hi, ovf_lo;
  logic signed [31:0] drive_nxt;
  logic signed [31:0] drive_r;
  logic               sat_r;

  pgd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  assign cfg_ready = 1'b1;

  // stage flow control, bubbles collapse
  assign adv4     = !out_valid_r || !out_stall;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;
  assign accept   = in_valid && adv1;

  // input stage: error, integral, rate correction
  assign err = 17'(in_setpoint) - 17'(in_measured);

  pgd_intg u_intg (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept),
    .err   (err),
    .sum   (isum),
    .sat   (isat)
  );

  always_comb begin
    rate_raw = 21'(in_yaw_rate) + 21'(cfg.rate_offset);
    rate_mag = rate_raw[20] ? 21'(-rate_raw) : 21'(rate_raw);
    rate_cor = (rate_mag <= 21'(cfg.rate_deadband)) ? '0 : rate_raw;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_err_r  <= err;
      s1_sum_r  <= isum;
      s1_rate_r <= rate_cor;
      s1_sat_r  <= isat;
    end
  end

  // multiplier stage
  always_comb begin
    prod_p   = 33'(cfg.gain_p) * 33'(s1_err_r);
    prod_i   = 48'(cfg.gain_i) * 48'(s1_sum_r);
    prod_d   = 37'(cfg.gain_d) * 37'(s1_rate_r);
    s2_a_nxt = 49'(prod_p) + 49'(prod_i);
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_a_r   <= s2_a_nxt;
      s2_x_r   <= 29'(prod_d >>> 8);
      s2_sat_r <= s1_sat_r;
    end
  end

  // floor divide of the damping term by 100 via biased reciprocal multiply
  always_comb begin
    div_in    = 30'(31'(s2_x_r) + 31'(DIV_BIAS));
    div_prod  = 61'(div_in) * 61'(RECIP_100);
    div_q     = div_prod[60:37];
    s3_qd_nxt = 24'($signed({1'b0, div_q}) - QUOT_BIAS);
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_a_r   <= s2_a_r;
      s3_qd_r  <= s3_qd_nxt;
      s3_sat_r <= s2_sat_r;
    end
  end

  // output stage: sum, floor by 2^8, clamp
  always_comb begin
    total   = 50'(s3_a_r) + 50'(s3_qd_r);
    floored = total >>> 8;
    ovf_hi  = !floored[49] && (|floored[48:31]);
    ovf_lo  = floored[49] && !(&floored[48:31]);
    priority if (ovf_hi) begin
      drive_nxt = INT32_MAX;
    end else if (ovf_lo) begin
      drive_nxt = INT32_MIN;
    end else begin
      drive_nxt = floored[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      drive_r <= drive_nxt;
      sat_r   <= s3_sat_r || ovf_hi || ovf_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= accept;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) out_valid_r <= v3_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive     = drive_r;
  assign out_saturated = sat_r;

endmodule

// ----- hdl/pgd_chk.sv -----
// pgd_chk: port-level checks for the gyro-damped pid core
// bound to positional_pid_gyro_damped_core; no package dependency
module pgd_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_drive,
  input logic               out_saturated
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_drive) && $stable(out_saturated))
    else $error("result changed while stalled");

  // input backpressure only comes from a stalled, full output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without output backpressure");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind positional_pid_gyro_damped_core pgd_chk u_pgd_chk (.*);

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for positional_pid_gyro_damped_core
// a drive predictor class checks every result transfer in order, with random idling on both
// channels; depends on pgd_pkg and the core rtl

localparam longint RATE_SCALE = 64'sd25600;
localparam longint DRIVE_DEN  = 64'sd6553600;

typedef struct packed {
  logic signed [31:0] drive;
  logic               sat;
} drive_word_t;

class drive_checker;
  logic signed [15:0] gain_p;
  logic signed [15:0] gain_i;
  logic signed [15:0] gain_d;
  logic signed [16:0] rate_offset;
  logic        [15:0] rate_deadband;
  logic signed [31:0] integ;
  drive_word_t        due[$];
  int                 fails;
  int                 checked;
  int                 sat_seen;
  int                 noted;
  int                 writes;

  function new();
    gain_p        = '0;
    gain_i        = '0;
    gain_d        = '0;
    rate_offset   = pgd_pkg::RATE_OFFSET_RST;
    rate_deadband = pgd_pkg::RATE_DEADBAND_RST;
    integ         = '0;
    fails         = 0;
    checked       = 0;
    sat_seen      = 0;
    noted         = 0;
    writes        = 0;
  endfunction

  function void write_reg(logic [pgd_pkg::CFG_IDX_W-1:0] idx,
                          logic [pgd_pkg::CFG_DATA_W-1:0] data);
    writes++;
    case (idx)
      pgd_pkg::REG_GAIN_P:        gain_p = data[15:0];
      pgd_pkg::REG_GAIN_I:        gain_i = data[15:0];
      pgd_pkg::REG_GAIN_D:        gain_d = data[15:0];
      pgd_pkg::REG_RATE_OFFSET:   rate_offset = data;
      pgd_pkg::REG_RATE_DEADBAND: rate_deadband = data[15:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return due.size();
  endfunction

  function void note_sample(logic signed [15:0] setpoint, logic signed [15:0] measured,
                            logic signed [19:0] yaw_rate);
    longint      rate;
    longint      err;
    longint      total;
    longint      num;
    longint      q;
    drive_word_t w;
    w.sat = 1'b0;
    rate = longint'(yaw_rate) + longint'(rate_offset);
    if ((rate < 0 ? -rate : rate) <= longint'(rate_deadband)) rate = 0;
    err   = longint'(setpoint) - longint'(measured);
    total = longint'(integ) + err;
    if (total > longint'(pgd_pkg::INT32_MAX)) begin
      total = pgd_pkg::INT32_MAX;
      w.sat = 1'b1;
    end else if (total < longint'(pgd_pkg::INT32_MIN)) begin
      total = pgd_pkg::INT32_MIN;
      w.sat = 1'b1;
    end
    integ = total[31:0];
    num = (longint'(gain_p) * err + longint'(gain_i) * total) * RATE_SCALE
        + longint'(gain_d) * rate;
    q = num / DRIVE_DEN;
    // floor toward minus infinity
    if (num % DRIVE_DEN != 0 && num < 0) q = q - 1;
    if (q > longint'(pgd_pkg::INT32_MAX)) begin
      q     = pgd_pkg::INT32_MAX;
      w.sat = 1'b1;
    end else if (q < longint'(pgd_pkg::INT32_MIN)) begin
      q     = pgd_pkg::INT32_MIN;
      w.sat = 1'b1;
    end
    w.drive = q[31:0];
    due.push_back(w);
    noted++;
  endfunction

  function void check_drive(logic signed [31:0] drive, logic sat);
    drive_word_t w;
    if (due.size() == 0) begin
      fails++;
      $error("result with nothing pending: drive %0d saturated %0b", drive, sat);
      return;
    end
    w = due.pop_front();
    checked++;
    if (w.sat) sat_seen++;
    if (drive !== w.drive) begin
      fails++;
      $error("drive mismatch: expected %0d, actual %0d", w.drive, drive);
    end
    if (sat !== w.sat) begin
      fails++;
      $error("saturated mismatch: expected %0b, actual %0b", w.sat, sat);
    end
  endfunction
endclass

module tb_top;
  import pgd_pkg::*;

  localparam int LIMIT = 1_000_000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [15:0]    in_setpoint = '0;
  logic signed [15:0]    in_measured = '0;
  logic signed [19:0]    in_yaw_rate = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [31:0]    out_drive;
  logic                  out_saturated;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  drive_checker drive_chk;
  bit           tx_idle = 1'b0;
  bit           rx_idle = 1'b0;
  int           hold_cycles = 0;
  int           stall_left = 0;
  int           run_left = 0;
  int           cycles = 0;

  positional_pid_gyro_damped_core u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // receiver side: long hold-off wins over random stalls
  always @(posedge clk) if (hold_cycles > 0) hold_cycles--;

  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (run_left > 0) run_left--;
    else if (rx_idle) begin
      stall_left = pick_gap();
      run_left   = $urandom_range(1, 12);
    end
    out_stall <= (hold_cycles > 0) || (stall_left > 0);
  end

  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid && !out_stall) drive_chk.check_drive(out_drive, out_saturated);
    if (cycles >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [19:0] rand_rate();
    int edge_pt;
    case ($urandom_range(0, 7))
      0: return 20'sh7ffff;
      1: return 20'sh80000;
      2, 3: begin
        // land on or next to the deadband boundary
        edge_pt = ($urandom_range(0, 1) ? 1 : -1) * int'(drive_chk.rate_deadband)
                - int'(drive_chk.rate_offset) + $urandom_range(0, 4) - 2;
        return 20'(edge_pt);
      end
      4: return 20'($urandom_range(0, 4000) - 2000);
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic send_sample(int gap, logic signed [15:0] sp, logic signed [15:0] ms,
                             logic signed [19:0] yr);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_setpoint <= sp;
    in_measured <= ms;
    in_yaw_rate <= yr;
    do @(posedge clk); while (in_stall);
    drive_chk.note_sample(sp, ms, yr);
  endtask

  task automatic random_samples(int n);
    repeat (n) send_sample(tx_idle ? pick_gap() : 0, rand_word(), rand_word(), rand_rate());
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drive_chk.pending() != 0) @(posedge clk);
  endtask

  task automatic quiesce();
    wait_drained();
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    drive_chk.write_reg(idx, data);
  endtask

  task automatic apply_config(logic [16:0] kp, logic [16:0] ki, logic [16:0] kd,
                              logic [16:0] offset, logic [16:0] deadband);
    logic [CFG_IDX_W-1:0] bad_idx;
    bad_idx = REG_RATE_DEADBAND + CFG_IDX_W'($urandom_range(1, 3));
    quiesce();
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_RATE_OFFSET, offset);
    write_reg(bad_idx, 17'($urandom));
    write_reg(REG_RATE_DEADBAND, deadband);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    drive_chk = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: zero gains
    send_sample(0, 16'sh7fff, 16'sh8000, 20'sh7ffff);
    send_sample(1, 16'sh8000, 16'sh7fff, 20'sh80000);
    send_sample(0, 16'sd5, -16'sd3, 20'sd0);

    // gains only, offset and deadband keep their reset values
    quiesce();
    write_reg(REG_GAIN_P, 17'd300);
    write_reg(REG_GAIN_I, -17'sd7);
    write_reg(REG_GAIN_D, 17'd20000);
    @(negedge clk);
    cfg_valid <= 1'b0;

    send_sample(0, 16'sh7fff, 16'sh8000, 20'sh7ffff);
    send_sample(0, 16'sh8000, 16'sh7fff, 20'sh80000);
    send_sample(0, 16'sd0, 16'sd0, -20'sd359);
    send_sample(0, 16'sd0, 16'sd0, -20'sd358);
    send_sample(0, 16'sd0, 16'sd0, -20'sd2919);
    send_sample(0, 16'sd0, 16'sd0, -20'sd2920);
    send_sample(0, 16'sd0, 16'sd0, -20'sd1639);
    send_sample(0, -16'sd1, 16'sd0, -20'sd1639);
    send_sample(0, 16'sd1, 16'sd0, -20'sd1639);
    send_sample(0, 16'sd0, 16'sd0, 20'sd0);
    send_sample(0, 16'sh7fff, 16'sh7fff, 20'sd0);
    send_sample(0, 16'sh8000, 16'sh8000, 20'sd0);
    send_sample(0, 16'sd12345, -16'sd54, 20'sd100000);
    send_sample(0, 16'sd0, 16'sd0, 20'sh80000);
    send_sample(0, -16'sd3, 16'sd2, 20'sh7ffff);

    // all maximum
    apply_config(17'd32767, 17'd32767, 17'd32767, 17'd65535, 17'd65535);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    random_samples(110);

    // all minimum, with a long receiver hold-off while the sender keeps offering
    apply_config(-17'sd32768, -17'sd32768, -17'sd32768, -17'sd65536, 17'd0);
    random_samples(50);
    hold_cycles = 80;
    repeat (40) send_sample(0, rand_word(), rand_word(), rand_rate());
    random_samples(20);

    // random settings, no idling
    apply_config(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    random_samples(110);

    // integral pushed hard one way, then the other
    apply_config(17'($urandom), 17'd32767, 17'($urandom), 17'($urandom), 17'($urandom));
    repeat (20) send_sample(0, 16'sh7fff, 16'sh8000, rand_rate());
    random_samples(10);
    repeat (20) send_sample(0, 16'sh8000, 16'sh7fff, rand_rate());

    // small gains, sender pauses until the pipe is empty halfway
    apply_config(17'd256, 17'd1, -17'sd1000, 17'd0, 17'd1280);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    random_samples(55);
    wait_drained();
    random_samples(55);

    apply_config(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
    random_samples(80);

    apply_config(17'($urandom_range(0, 512)), 17'($urandom_range(0, 8)),
                 17'($urandom), 17'($urandom), 17'($urandom_range(0, 4000)));
    random_samples(80);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("%0d samples sent, %0d results checked, %0d of them saturated",
             drive_chk.noted, drive_chk.checked, drive_chk.sat_seen);
    $display("%0d register writes across extreme, random and small settings, %0d failures",
             drive_chk.writes, drive_chk.fails);
    if (drive_chk.fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
